// ===== hw/rtl/haar_wavelet_2d_step_assert.svh =====
// Assertion macros shared by the checker of the Haar wavelet block.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef HAAR_WAVELET_2D_STEP_ASSERT_SVH
`define HAAR_WAVELET_2D_STEP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define HWT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hwt check failed: same-cycle rule");

// Next-cycle implication, checked at every rising edge outside reset.
`define HWT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hwt check failed: next-cycle rule");

`endif

// ===== hw/rtl/hwt_pkg.sv =====
// Package of the one-level 2-D Haar wavelet block: widths, register
// indexes, reset values and the structs passed between modules. No dependencies.
`default_nettype none

package hwt_pkg;

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 10;
    localparam int BLK_W      = 9;
    localparam int CFG_W      = 11;
    localparam int ROW_W      = 10;
    localparam int MAX_LINES  = 1024;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 64;
    localparam int CFG_IDX_W  = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = 1'b1;

    localparam logic [CFG_W-1:0] LINE_LENGTH_RST = 11'd400;
    localparam logic [CFG_W-1:0] LINE_COUNT_RST  = 11'd400;

    typedef logic [PIX_W-1:0]         pix_t;
    typedef logic signed [COEF_W-1:0] coef_t;

    // The four pixels of a 2x2 block: a, b on top, c, d below.
    typedef struct packed {
        pix_t a;
        pix_t b;
        pix_t c;
        pix_t d;
    } quad_t;

    typedef struct packed {
        logic [COEF_W-1:0] average_sum;
        coef_t             vertical_detail;
        coef_t             horizontal_detail;
        coef_t             diagonal_detail;
    } coef_set_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hwt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module hwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/hwt_coef.sv =====
// Butterfly of the one-level Haar transform: four exact coefficient sums
// from one 2x2 block. Depends on hwt_pkg.
`default_nettype none

module hwt_coef (
    input  wire hwt_pkg::quad_t     quad,
    output hwt_pkg::coef_set_t      coef
);

    logic [hwt_pkg::COEF_W-1:0] sum_top;
    logic [hwt_pkg::COEF_W-1:0] sum_bot;
    logic [hwt_pkg::COEF_W-1:0] dif_top;
    logic [hwt_pkg::COEF_W-1:0] dif_bot;

    // All values fit in 10 bits, so modulo arithmetic gives exact results.
    assign sum_top = hwt_pkg::COEF_W'(quad.a) + hwt_pkg::COEF_W'(quad.b);
    assign sum_bot = hwt_pkg::COEF_W'(quad.c) + hwt_pkg::COEF_W'(quad.d);
    assign dif_top = hwt_pkg::COEF_W'(quad.a) - hwt_pkg::COEF_W'(quad.b);
    assign dif_bot = hwt_pkg::COEF_W'(quad.c) - hwt_pkg::COEF_W'(quad.d);

    assign coef.average_sum       = sum_top + sum_bot;
    assign coef.vertical_detail   = sum_top - sum_bot;
    assign coef.horizontal_detail = dif_top + dif_bot;
    assign coef.diagonal_detail   = dif_top - dif_bot;

endmodule

`default_nettype wire

// ===== hw/rtl/haar_wavelet_2d_step.sv =====
// One-level 2-D Haar wavelet on a raster pixel stream: the top level.
// Depends on hwt_pkg, hwt_ram and hwt_coef.
//
// The block takes one 8-bit pixel word per clock in raster order and, on
// the pixel that closes a 2x2 block (odd column of an odd row), returns
// one word with the four Haar coefficients as exact sums (four times the
// normalized values), the block coordinates and a last-block flag on
// tlast. Pixels of a trailing odd column or row are taken but cause no
// word. Sustained rate is one pixel word per cycle outside the clearing
// pass and while m_tready keeps the output moving; a result word passes a
// two-word pipeline (block register, output register) between the line
// buffer read and m_tdata, so m_tready low stalls input only once both
// are full. The line buffer is split into an even-column and an
// odd-column bank of (MAX_LINE+1)/2 entries each, so both top pixels of
// a block come out of one registered read. After reset the banks are
// cleared to zero, one entry per cycle, with s_tready low; configuration
// writes are taken during that pass. A word with tuser set places its
// pixel at column 0 of row 0; otherwise the position simply wraps at
// the end of each line and frame. line_length is clamped to 2..MAX_LINE
// and line_count to 2..1024. Write configuration only while the block
// is idle.
`default_nettype none

module haar_wavelet_2d_step #(
    parameter int MAX_LINE = 1024
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    // Pixel input. s_tdata: pixel [7:0]. s_tuser: frame_start [0].
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [hwt_pkg::IN_DATA_W-1:0]        s_tdata,
    input  wire logic                                 s_tuser,

    // Coefficient output. m_tdata: average_sum [9:0], vertical_detail
    // [19:10], horizontal_detail [29:20], diagonal_detail [39:30],
    // block_column [48:40], block_row [57:49], zero fill [63:58].
    // m_tlast: last_block.
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic      [hwt_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                      m_tlast,

    // Configuration write port.
    input  wire logic                                 cfg_we,
    input  wire logic [hwt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [hwt_pkg::CFG_W-1:0]            cfg_data
);

    // Column positions need COL_W bits, each bank half of that address.
    localparam int COL_W  = $clog2(MAX_LINE);
    localparam int BA_W   = COL_W - 1;
    localparam int BANK_D = (MAX_LINE + 1) / 2;
    localparam int LEN_W  = $clog2(MAX_LINE + 1);
    localparam int CMP_W  = (LEN_W > hwt_pkg::CFG_W) ? LEN_W : hwt_pkg::CFG_W;
    localparam logic [BA_W-1:0] BANK_LAST = BA_W'(BANK_D - 1);

    // Configuration registers.
    logic [hwt_pkg::CFG_W-1:0] line_length_reg;
    logic [hwt_pkg::CFG_W-1:0] line_count_reg;

    // Position and previous pixel.
    logic [COL_W-1:0]          col_cnt_reg;
    logic [COL_W-1:0]          col_cnt_next;
    logic [hwt_pkg::ROW_W-1:0] row_cnt_reg;
    logic [hwt_pkg::ROW_W-1:0] row_cnt_next;
    hwt_pkg::pix_t             held_reg;

    // Clearing pass over the line buffer banks.
    logic                      clear_active_reg;
    logic [BA_W-1:0]           clear_addr_reg;

    // Block register: the lower pixels and the block tags.
    logic                      s1_valid_reg;
    hwt_pkg::pix_t             s1_c_reg;
    hwt_pkg::pix_t             s1_d_reg;
    logic [hwt_pkg::BLK_W-1:0] s1_col_reg;
    logic [hwt_pkg::BLK_W-1:0] s1_row_reg;
    logic                      s1_last_reg;

    // Output register.
    logic                      out_valid_reg;
    hwt_pkg::coef_set_t        out_coef_reg;
    logic [hwt_pkg::BLK_W-1:0] out_col_reg;
    logic [hwt_pkg::BLK_W-1:0] out_row_reg;
    logic                      out_last_reg;

    // Effective line length and line count after clamping.
    logic [CMP_W-1:0]          len_wide;
    logic [LEN_W-1:0]          len;
    logic [hwt_pkg::CFG_W-1:0] cnt;
    logic [COL_W-1:0]          col_last;
    logic [COL_W-1:0]          blk_col_last;
    logic [hwt_pkg::ROW_W-1:0] row_last;
    logic [hwt_pkg::ROW_W-1:0] blk_row_last;

    logic [COL_W-1:0]          col_base;
    logic [COL_W-1:0]          col;
    logic [hwt_pkg::ROW_W-1:0] row_base;
    logic [hwt_pkg::ROW_W-1:0] row;
    logic [BA_W-1:0]           col_half;

    logic                      accept;
    logic                      produce;
    logic                      out_free;
    logic                      wr_even;
    logic                      wr_odd;
    logic                      bank_even_we;
    logic                      bank_odd_we;
    logic [BA_W-1:0]           bank_waddr;
    hwt_pkg::pix_t             bank_wdata;
    hwt_pkg::pix_t             top_left;
    hwt_pkg::pix_t             top_right;
    hwt_pkg::pix_t             pixel;

    hwt_pkg::quad_t            quad;
    hwt_pkg::coef_set_t        coef;

    assign pixel = s_tdata[hwt_pkg::PIX_W-1:0];

    // Clamp line_length to 2..MAX_LINE; compare at a width that holds both.
    assign len_wide = CMP_W'(line_length_reg);

    always_comb
    begin
        if (len_wide < CMP_W'(2))
        begin
            len = LEN_W'(2);
        end
        else if (len_wide > CMP_W'(MAX_LINE))
        begin
            len = LEN_W'(MAX_LINE);
        end
        else
        begin
            len = LEN_W'(len_wide);
        end
    end

    // Clamp line_count to 2..1024.
    always_comb
    begin
        if (line_count_reg < hwt_pkg::CFG_W'(2))
        begin
            cnt = hwt_pkg::CFG_W'(2);
        end
        else if (line_count_reg > hwt_pkg::CFG_W'(hwt_pkg::MAX_LINES))
        begin
            cnt = hwt_pkg::CFG_W'(hwt_pkg::MAX_LINES);
        end
        else
        begin
            cnt = line_count_reg;
        end
    end

    assign col_last     = COL_W'(len - LEN_W'(1));
    assign blk_col_last = COL_W'({len[LEN_W-1:1], 1'b0} - LEN_W'(1));
    assign row_last     = hwt_pkg::ROW_W'(cnt - hwt_pkg::CFG_W'(1));
    assign blk_row_last =
        hwt_pkg::ROW_W'({cnt[hwt_pkg::CFG_W-1:1], 1'b0} - hwt_pkg::CFG_W'(1));

    // Position of this pixel: a frame start restarts at the origin, and a
    // counter left past a shortened line or frame is pulled back to its end.
    assign col_base = s_tuser ? '0 : col_cnt_reg;
    assign row_base = s_tuser ? '0 : row_cnt_reg;
    assign col      = (col_base >= col_last) ? col_last : col_base;
    assign row      = (row_base >= row_last) ? row_last : row_base;
    assign col_half = col[COL_W-1:1];

    // Handshakes. The block register advances whenever the output register is
    // empty or read; a pixel is refused while clearing or when both are full.
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !clear_active_reg && (!s1_valid_reg || out_free);
    assign accept   = s_tvalid && s_tready;

    // Even rows fill the line buffer; odd columns of odd rows close a block.
    assign wr_even = accept && !row[0] && !col[0];
    assign wr_odd  = accept && !row[0] && col[0];
    assign produce = accept && row[0] && col[0];

    assign bank_even_we = clear_active_reg || wr_even;
    assign bank_odd_we  = clear_active_reg || wr_odd;
    assign bank_waddr   = clear_active_reg ? clear_addr_reg : col_half;
    assign bank_wdata   = clear_active_reg ? '0 : pixel;

    hwt_ram #(
        .WIDTH (hwt_pkg::PIX_W),
        .DEPTH (BANK_D)
    ) u_bank_even (
        .clk   (clk),
        .we    (bank_even_we),
        .waddr (bank_waddr),
        .wdata (bank_wdata),
        .re    (produce),
        .raddr (col_half),
        .rdata (top_left)
    );

    hwt_ram #(
        .WIDTH (hwt_pkg::PIX_W),
        .DEPTH (BANK_D)
    ) u_bank_odd (
        .clk   (clk),
        .we    (bank_odd_we),
        .waddr (bank_waddr),
        .wdata (bank_wdata),
        .re    (produce),
        .raddr (col_half),
        .rdata (top_right)
    );

    // Next position: wrap at the end of the line, then at the end of the frame.
    always_comb
    begin
        if (col == col_last)
        begin
            col_cnt_next = '0;
            row_cnt_next = (row == row_last) ? '0 : row + hwt_pkg::ROW_W'(1);
        end
        else
        begin
            col_cnt_next = col + COL_W'(1);
            row_cnt_next = row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg  <= hwt_pkg::LINE_LENGTH_RST;
            line_count_reg   <= hwt_pkg::LINE_COUNT_RST;
            col_cnt_reg      <= '0;
            row_cnt_reg      <= '0;
            held_reg         <= '0;
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    hwt_pkg::REG_LINE_LENGTH: line_length_reg <= cfg_data;
                    hwt_pkg::REG_LINE_COUNT:  line_count_reg  <= cfg_data;
                    default: ;
                endcase
            end

            if (clear_active_reg)
            begin
                clear_addr_reg <= clear_addr_reg + BA_W'(1);
                if (clear_addr_reg == BANK_LAST)
                begin
                    clear_active_reg <= 1'b0;
                end
            end

            if (accept)
            begin
                col_cnt_reg <= col_cnt_next;
                row_cnt_reg <= row_cnt_next;
                held_reg    <= pixel;
            end

            if (produce)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // The bottom-left pixel is the one held from the previous word.
    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            s1_c_reg    <= held_reg;
            s1_d_reg    <= pixel;
            s1_col_reg  <= hwt_pkg::BLK_W'(col_half);
            s1_row_reg  <= hwt_pkg::BLK_W'(row[hwt_pkg::ROW_W-1:1]);
            s1_last_reg <= (col == blk_col_last) && (row == blk_row_last);
        end
        if (out_free && s1_valid_reg)
        begin
            out_coef_reg <= coef;
            out_col_reg  <= s1_col_reg;
            out_row_reg  <= s1_row_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    assign quad.a = top_left;
    assign quad.b = top_right;
    assign quad.c = s1_c_reg;
    assign quad.d = s1_d_reg;

    hwt_coef u_coef (
        .quad (quad),
        .coef (coef)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {
        6'b0,
        out_row_reg,
        out_col_reg,
        out_coef_reg.diagonal_detail,
        out_coef_reg.horizontal_detail,
        out_coef_reg.vertical_detail,
        out_coef_reg.average_sum
    };

endmodule

`default_nettype wire

// ===== hw/rtl/hwt_checker.sv =====
// Port-level checker for the Haar wavelet block, bound to its top level.
// Depends on hwt_pkg and haar_wavelet_2d_step_assert.svh.
`default_nettype none

`include "haar_wavelet_2d_step_assert.svh"

module hwt_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [hwt_pkg::OUT_DATA_W-1:0] m_tdata,
    input wire logic                           m_tlast
);

    logic s_acc;

    assign s_acc = s_tvalid && s_tready;

    // A word that is not taken stays on the bus unchanged.
    `HWT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // A word needs an earlier pixel, passed through the block and output
    // registers: with no word shown and no pixel taken, nothing comes out.
    `HWT_ASSERT_NEXT(a_no_phantom, !m_tvalid && !s_acc ##1 !m_tvalid && !s_acc, !m_tvalid)

    // The sum of four 8-bit pixels never exceeds 1020.
    `HWT_ASSERT_NOW(a_avg_range, m_tvalid, m_tdata[9:0] <= 10'd1020)

    // The four coefficients differ pairwise by even amounts.
    `HWT_ASSERT_NOW(a_parity, m_tvalid, (m_tdata[0] == m_tdata[10]) && (m_tdata[0] == m_tdata[20]) && (m_tdata[0] == m_tdata[30]))

endmodule

bind haar_wavelet_2d_step hwt_checker u_hwt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
